// File: hw/rtl/mlcd_pkg.sv
// ----------------------------------------------------------------------------
// mlcd_pkg
// Shared constants and helpers for the marker/length/CRC deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlcd_pkg;

   // request opcodes (travel on req_tuser)
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // frame constants
   localparam logic [7:0]  MARK       = 8'h78;
   localparam logic [7:0]  STOP_CR    = 8'h0D;
   localparam logic [7:0]  STOP_LF    = 8'h0A;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h8408;
   localparam logic [8:0]  MIN_FRAME  = 9'd8;

   // result cap per request transaction
   localparam logic [3:0]  MAX_RESULTS = 4'd12;

   // number of length candidates tried
   localparam logic [1:0]  NUM_CAND = 2'd3;

   // extra bytes added to the length field for each candidate, in try order
   function automatic logic [3:0] len_extra(input logic [1:0] k);
      logic [3:0] e;
      case (k)
         2'd0:    e = 4'd6;
         2'd1:    e = 4'd7;
         default: e = 4'd5;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mlcd_ram.sv
// ----------------------------------------------------------------------------
// mlcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mlcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 96
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/marker_length_crc_deframer_core.sv
// ----------------------------------------------------------------------------
// marker_length_crc_deframer_core
// Byte-serial deframer: 78 78 | type | len | content | crc | stop stop.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction per received byte (req_tuser = 0) or a
//   flush (req_tuser = 1). The byte goes into a circular reassembly buffer
//   of BUF_BYTES entries; when full, the oldest byte is dropped.
//   After each byte a sequencer rescans the buffer for the marker, tries
//   the three length candidates and runs a bit-serial CRC-16/X-25 over each
//   complete candidate, one bit per cycle through a single CRC step unit.
//   Each decoded frame leaves on the rsp channel as 8-byte content words,
//   rsp_tlast on the final one; at most 12 words per request.
//   Sequencing: every scanned buffer byte takes a read and a compare state
//   (one RAM read port, registered data); each CRC byte takes a read state,
//   an XOR state and one bit step per bit; each emitted word reads its bytes
//   one at a time into the word.
//   req_tready is high only while the sequencer is idle.
//   A stalled receiver holds the sequencer before the next word; the last
//   word waits in the output register while new bytes are accepted.
//   Reset empties the buffer at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_length_crc_deframer_core
   import mlcd_pkg::*;
#(
   parameter int BUF_BYTES = 96
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: opcode on tuser; tdata = rx_byte[7:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  wire logic        req_tuser,   // opcode
   // response: tdata = frame_type[7:0], content_length[14:8],
   // word_index[18:15], content_word[82:19], valid_bytes[86:83], zero[87]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,
   output logic             rsp_tlast    // last
);

   localparam int AW = $clog2(BUF_BYTES);
   localparam int CW = $clog2(BUF_BYTES + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_CMP, S_HDR_A, S_HDR_B, S_HDR_C,
      S_CAND, S_T0, S_T1, S_T2, S_T3, S_T4, S_CRC_RD, S_CRC_XOR, S_CRC_BIT,
      S_CRC_DONE, S_EM_NEXT, S_EM_RD, S_EM_CAP
   } state_type;

   // logical buffer index to physical RAM address (wraps once)
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [8:0] lidx);
      logic [9:0] sum;
      sum = 10'(head) + 10'(lidx);
      if (sum >= 10'(BUF_BYTES)) begin
         sum = sum - 10'(BUF_BYTES);
      end
      return sum[AW-1:0];
   endfunction

   state_type    state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [8:0]   idx_ff, idx_in;
   logic [7:0]   prev_ff, prev_in;
   logic [7:0]   type_ff, type_in;
   logic [7:0]   len_ff, len_in;
   logic [1:0]   k_ff, k_in;
   logic         wait_ff, wait_in;
   logic [8:0]   total_ff, total_in;
   logic [7:0]   s0_ff, s0_in, s1_ff, s1_in, hi_ff, hi_in, lo_ff, lo_in;
   logic [15:0]  crc_ff, crc_in;
   logic [2:0]   bit_ff, bit_in;
   logic [63:0]  word_ff, word_in;
   logic [3:0]   bi_ff, bi_in;
   logic [4:0]   w_ff, w_in;
   logic [3:0]   n_ff, n_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [87:0]  rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;

   logic         ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]   ram_rdata;
   logic [8:0]   rd_lidx;

   // working values
   logic [8:0]   fill9, total_c, fill_left, clen, base, rem;
   logic [3:0]   cnt;
   logic         last_w, stop_ok, full;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   mlcd_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_tdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // read address selection
   always_comb begin
      unique case (state_ff)
         S_SCAN_RD, S_CRC_RD: rd_lidx = idx_ff;
         S_HDR_A:  rd_lidx = 9'd2;
         S_HDR_B:  rd_lidx = 9'd3;
         S_T0:     rd_lidx = total_ff - 9'd2;
         S_T1:     rd_lidx = total_ff - 9'd1;
         S_T2:     rd_lidx = total_ff - 9'd4;
         S_T3:     rd_lidx = total_ff - 9'd3;
         S_EM_RD:  rd_lidx = 9'd4 + {1'b0, w_ff, 3'b000} + 9'(bi_ff);
         default:  rd_lidx = 9'd0;
      endcase
      ram_raddr = phys(head_ff, rd_lidx);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      type_in      = type_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      wait_in      = wait_ff;
      total_in     = total_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      crc_in       = crc_ff;
      bit_in       = bit_ff;
      word_in      = word_ff;
      bi_in        = bi_ff;
      w_in         = w_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;

      fill9     = 9'(fill_ff);
      full      = (fill9 == 9'(BUF_BYTES));
      ram_waddr = full ? head_ff : phys(head_ff, fill9);
      total_c   = 9'(len_ff) + 9'(len_extra(k_ff));
      fill_left = fill9 - (idx_ff - 9'd1);
      clen      = total_ff - MIN_FRAME;
      base      = {1'b0, w_ff, 3'b000};
      rem       = (clen > base) ? (clen - base) : 9'd0;
      cnt       = (rem > 9'd8) ? 4'd8 : rem[3:0];
      last_w    = (clen <= base + 9'd8);
      stop_ok   = (s0_ff == STOP_CR && s1_ff == STOP_LF) ||
                  (s0_ff == STOP_LF && s1_ff == STOP_CR);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_FLUSH) begin
                  fill_in = '0;
               end else begin
                  ram_we = 1'b1;
                  if (full) begin
                     head_in = phys(head_ff, 9'd1);
                  end else begin
                     fill_in = fill_ff + 1'b1;
                  end
                  n_in     = '0;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (fill9 < MIN_FRAME) begin
               state_in = S_IDLE;
            end else begin
               idx_in   = '0;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (idx_ff != 9'd0 && prev_ff == MARK && ram_rdata == MARK) begin
               // marker at idx-1: move it to the front
               head_in  = phys(head_ff, idx_ff - 9'd1);
               fill_in  = fill_left[CW-1:0];
               state_in = (fill_left < MIN_FRAME) ? S_IDLE : S_HDR_A;
            end else if (idx_ff == fill9 - 9'd1) begin
               // no marker: keep only the newest byte
               head_in  = phys(head_ff, fill9 - 9'd1);
               fill_in  = CW'(1);
               state_in = S_IDLE;
            end else begin
               prev_in  = ram_rdata;
               idx_in   = idx_ff + 9'd1;
               state_in = S_SCAN_RD;
            end
         end
         S_HDR_A: state_in = S_HDR_B;
         S_HDR_B: begin
            type_in  = ram_rdata;
            state_in = S_HDR_C;
         end
         S_HDR_C: begin
            len_in   = ram_rdata;
            k_in     = '0;
            wait_in  = 1'b0;
            state_in = S_CAND;
         end
         // length candidates
         S_CAND: begin
            if (k_ff == NUM_CAND) begin
               if (wait_ff) begin
                  state_in = S_IDLE;
               end else begin
                  // marker is noise: drop it
                  head_in  = phys(head_ff, 9'd2);
                  fill_in  = fill_ff - CW'(2);
                  state_in = S_CHECK;
               end
            end else if (total_c < MIN_FRAME || total_c > 9'(BUF_BYTES)) begin
               k_in = k_ff + 2'd1;
            end else if (fill9 < total_c) begin
               wait_in = 1'b1;
               k_in    = k_ff + 2'd1;
            end else begin
               total_in = total_c;
               state_in = S_T0;
            end
         end
         S_T0: state_in = S_T1;
         S_T1: begin
            s0_in    = ram_rdata;
            state_in = S_T2;
         end
         S_T2: begin
            s1_in    = ram_rdata;
            state_in = S_T3;
         end
         S_T3: begin
            hi_in    = ram_rdata;
            state_in = S_T4;
         end
         S_T4: begin
            lo_in    = ram_rdata;
            crc_in   = CRC_INIT;
            idx_in   = 9'd2;
            state_in = S_CRC_RD;
         end
         // bit-serial CRC-16/X-25 over type, len and content
         S_CRC_RD: state_in = S_CRC_XOR;
         S_CRC_XOR: begin
            crc_in   = crc_ff ^ {8'h00, ram_rdata};
            bit_in   = '0;
            state_in = S_CRC_BIT;
         end
         S_CRC_BIT: begin
            crc_in = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               idx_in   = idx_ff + 9'd1;
               state_in = (idx_ff + 9'd1 == total_ff - 9'd4) ? S_CRC_DONE : S_CRC_RD;
            end
         end
         S_CRC_DONE: begin
            if (stop_ok && ~crc_ff == {hi_ff, lo_ff}) begin
               w_in     = '0;
               bi_in    = '0;
               word_in  = '0;
               state_in = S_EM_NEXT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_CAND;
            end
         end
         // content words
         S_EM_NEXT: begin
            if (bi_ff != cnt) begin
               state_in = S_EM_RD;
            end else if (n_ff < MAX_RESULTS && rsp_valid_ff && !rsp_tready) begin
               state_in = S_EM_NEXT;
            end else begin
               if (n_ff < MAX_RESULTS) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {1'b0, cnt, word_ff, w_ff[3:0], clen[6:0], type_ff};
                  rsp_last_in  = last_w;
                  n_in         = n_ff + 4'd1;
               end
               if (last_w) begin
                  // consume the frame
                  head_in  = phys(head_ff, total_ff);
                  fill_in  = fill_ff - total_ff[CW-1:0];
                  state_in = S_CHECK;
               end else begin
                  w_in     = w_ff + 5'd1;
                  bi_in    = '0;
                  word_in  = '0;
                  state_in = S_EM_NEXT;
               end
            end
         end
         S_EM_RD: state_in = S_EM_CAP;
         S_EM_CAP: begin
            word_in[bi_ff[2:0]*8 +: 8] = ram_rdata;
            bi_in    = bi_ff + 4'd1;
            state_in = S_EM_NEXT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      prev_ff     <= prev_in;
      type_ff     <= type_in;
      len_ff      <= len_in;
      k_ff        <= k_in;
      wait_ff     <= wait_in;
      total_ff    <= total_in;
      s0_ff       <= s0_in;
      s1_ff       <= s1_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      crc_ff      <= crc_in;
      bit_ff      <= bit_in;
      word_ff     <= word_in;
      bi_ff       <= bi_in;
      w_ff        <= w_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

// File: bench/mlcd_checker.sv
// ----------------------------------------------------------------------------
// mlcd_checker
// Watches the request and response channels of the deframer, keeps its own
// copy of the reassembly buffer, decodes frames per accepted byte and checks
// every response word against the oldest decoded word.
// ----------------------------------------------------------------------------
`default_nettype none

module mlcd_checker
   import mlcd_pkg::*;
#(
   parameter int BUF_BYTES = 96
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [87:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   output int               fail_count,
   output int               words_pending
);

   typedef struct packed {
      logic [7:0]  frame_type;
      logic [6:0]  content_length;
      logic [3:0]  word_index;
      logic [63:0] content_word;
      logic [3:0]  valid_bytes;
      logic        last;
   } word_type;

   word_type   word_q[$];
   logic [7:0] rx_buf[BUF_BYTES];
   int         rx_fill;

   assign words_pending = word_q.size();

   // CRC-16/X-25 over rx_buf[from +: count]
   function automatic logic [15:0] x25_sum(input int from, input int count);
      logic [15:0] fcs;
      fcs = CRC_INIT;
      for (int i = 0; i < count; i++) begin
         fcs ^= {8'h00, rx_buf[from + i]};
         for (int b = 0; b < 8; b++)
            fcs = fcs[0] ? ((fcs >> 1) ^ CRC_POLY) : (fcs >> 1);
      end
      return ~fcs;
   endfunction

   function automatic int len_extra_of(input int k);
      return (k == 0) ? 6 : (k == 1) ? 7 : 5;
   endfunction

   task automatic shift_out(input int n);
      if (n >= rx_fill) begin
         rx_fill = 0;
      end else begin
         for (int i = 0; i < rx_fill - n; i++)
            rx_buf[i] = rx_buf[i + n];
         rx_fill -= n;
      end
   endtask

   // one decode attempt; returns 1 and frame fields when a frame is consumed
   task automatic try_decode(output bit got, output logic [7:0] ftype,
                             output logic [7:0] body[BUF_BYTES], output int clen);
      int  start;
      bit  found, waiting;
      int  total;
      logic [7:0] s0, s1;
      got = 0;
      clen = 0;
      ftype = '0;
      while (rx_fill >= 8) begin
         start = 0;
         found = 0;
         waiting = 0;
         while (start + 1 < rx_fill) begin
            if (rx_buf[start] == MARK && rx_buf[start + 1] == MARK) begin
               found = 1;
               break;
            end
            start++;
         end
         if (!found) begin
            rx_buf[0] = rx_buf[rx_fill - 1];
            rx_fill = 1;
            return;
         end
         if (start > 0) shift_out(start);
         if (rx_fill < 8) return;
         for (int k = 0; k < NUM_CAND; k++) begin
            total = int'(rx_buf[3]) + len_extra_of(k);
            if (total < 8 || total > BUF_BYTES) continue;
            if (rx_fill < total) begin
               waiting = 1;
               continue;
            end
            s0 = rx_buf[total - 2];
            s1 = rx_buf[total - 1];
            if (((s0 == STOP_CR && s1 == STOP_LF) || (s0 == STOP_LF && s1 == STOP_CR)) &&
                x25_sum(2, total - 6) == {rx_buf[total - 4], rx_buf[total - 3]}) begin
               ftype = rx_buf[2];
               clen = total - 8;
               for (int i = 0; i < clen; i++) body[i] = rx_buf[4 + i];
               shift_out(total);
               got = 1;
               return;
            end
         end
         if (waiting) return;
         shift_out(2);
      end
   endtask

   // predict the words caused by one request transaction
   task automatic predict_request(input logic op, input logic [7:0] data);
      bit         got;
      logic [7:0] ftype;
      logic [7:0] body[BUF_BYTES];
      int         clen, words, cnt, made;
      word_type   w;
      made = 0;
      if (op == OP_FLUSH) begin
         rx_fill = 0;
         return;
      end
      if (rx_fill >= BUF_BYTES) shift_out(rx_fill - BUF_BYTES + 1);
      rx_buf[rx_fill] = data;
      rx_fill++;
      forever begin
         try_decode(got, ftype, body, clen);
         if (!got) break;
         words = (clen == 0) ? 1 : (clen + 7) / 8;
         for (int i = 0; i < words; i++) begin
            if (made >= MAX_RESULTS) break;
            cnt = clen - 8 * i;
            if (cnt < 0) cnt = 0;
            if (cnt > 8) cnt = 8;
            w = '0;
            w.frame_type = ftype;
            w.content_length = clen[6:0];
            w.word_index = i[3:0];
            for (int j = 0; j < cnt; j++) w.content_word[8 * j +: 8] = body[8 * i + j];
            w.valid_bytes = cnt[3:0];
            w.last = (i + 1 == words);
            word_q.push_back(w);
            made++;
         end
      end
   endtask

   // channel monitor
   always @(posedge clock) begin
      word_type got_w, want;
      if (reset) begin
         rx_fill = 0;
         fail_count <= 0;
         word_q.delete();
      end else begin
         if (req_tvalid && req_tready) predict_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got_w = {rsp_tdata[7:0], rsp_tdata[14:8], rsp_tdata[18:15],
                     rsp_tdata[82:19], rsp_tdata[86:83], rsp_tlast};
            if (word_q.size() == 0) begin
               $display("%0t: unexpected response word: expected none, actual %h",
                        $time, got_w);
               fail_count <= fail_count + 1;
            end else begin
               want = word_q.pop_front();
               if (got_w !== want || rsp_tdata[87] !== 1'b0) begin
                  $display("%0t: response mismatch: expected %h, actual %h (pad %b)",
                           $time, want, got_w, rsp_tdata[87]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: bench/tb_marker_length_crc_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_marker_length_crc_deframer_core
// Feeds directed and random byte streams (valid frames, corrupted frames,
// noise, flushes) into the deframer with random gaps and back-pressure; the
// checker module predicts and compares every response word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_marker_length_crc_deframer_core;
   import mlcd_pkg::*;

   localparam int WATCHDOG = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = OP_APPEND;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          words_pending;
   int          idle_cycles;
   int          rsp_gap = 0;
   bit          hold_rsp = 0;
   logic [7:0]  frame_bytes[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   marker_length_crc_deframer_core u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   mlcd_checker u_chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .fail_count, .words_pending
   );

   function automatic int gap_len();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 2);
   endfunction

   // receiver: random stalls of random length, plus a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= gap_len();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // long receiver hold-off, counted in cycles
   task automatic hold_off(input int cycles);
      hold_rsp = 1;
      repeat (cycles) @(posedge clock);
      hold_rsp = 0;
   endtask

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send(input logic op, input logic [7:0] data, input bit no_gap);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_queue(input bit no_gap);
      foreach (frame_bytes[i]) send(OP_APPEND, frame_bytes[i], no_gap);
   endtask

   // build a frame; extra picks the length convention (6, 7 or 5)
   task automatic build_frame(input logic [7:0] ftype, input int clen, input int extra,
                              input bit swap_stop, input bit bad_crc, input bit fill_ff);
      logic [15:0] fcs;
      logic [7:0]  b[$];
      frame_bytes = {MARK, MARK};
      b = {ftype, 8'((clen + 8) - extra)};
      for (int i = 0; i < clen; i++) b.push_back(fill_ff ? 8'hFF : 8'($urandom));
      fcs = CRC_INIT;
      foreach (b[i]) begin
         fcs ^= {8'h00, b[i]};
         for (int k = 0; k < 8; k++) fcs = fcs[0] ? ((fcs >> 1) ^ CRC_POLY) : (fcs >> 1);
      end
      fcs = ~fcs;
      if (bad_crc) fcs ^= 16'h0001 << $urandom_range(0, 15);
      foreach (b[i]) frame_bytes.push_back(b[i]);
      frame_bytes.push_back(fcs[15:8]);
      frame_bytes.push_back(fcs[7:0]);
      frame_bytes.push_back(swap_stop ? STOP_LF : STOP_CR);
      frame_bytes.push_back(swap_stop ? STOP_CR : STOP_LF);
   endtask

   function automatic int pick_extra();
      int r;
      r = $urandom_range(0, 2);
      return (r == 0) ? 6 : (r == 1) ? 7 : 5;
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   int sent;
   int r;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty content, both stop orders, all length conventions
      build_frame(8'h00, 0, 6, 0, 0, 0); send_queue(0);
      build_frame(8'hFF, 8, 7, 1, 0, 1); send_queue(0);
      build_frame(8'hA5, 3, 5, 0, 0, 0); send_queue(0);
      // corrupted CRC: marker is noise
      build_frame(8'h12, 2, 6, 0, 1, 0); send_queue(0);
      // flush mid-frame, then a single noise byte
      send(OP_APPEND, MARK, 0); send(OP_APPEND, MARK, 0); send(OP_FLUSH, 8'hFF, 0);
      send(OP_APPEND, 8'h55, 0);
      drain();

      // pressure: long receiver stall while a large frame streams in
      fork
         hold_off(3000);
         begin
            build_frame(8'h3C, 88, 6, 0, 0, 0);
            send_queue(1);
            build_frame(8'h3D, 20, 7, 1, 0, 0);
            send_queue(1);
         end
      join
      drain();

      // random: mostly well-formed frames, some broken ones and noise
      sent = 0;
      while (sent < 330) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            build_frame(8'($urandom), ($urandom_range(0, 7) == 0) ? $urandom_range(0, 88)
                        : $urandom_range(0, 17), pick_extra(), $urandom_range(0, 1), 0,
                        $urandom_range(0, 9) == 0);
            send_queue(0);
            sent += frame_bytes.size();
         end else if (r < 8) begin
            build_frame(8'($urandom), $urandom_range(0, 12), pick_extra(),
                        $urandom_range(0, 1), 1, 0);
            if ($urandom_range(0, 1)) frame_bytes[frame_bytes.size() - 1] = 8'($urandom);
            send_queue(0);
            sent += frame_bytes.size();
         end else if (r == 8) begin
            repeat ($urandom_range(1, 6)) begin
               send(OP_APPEND, ($urandom_range(0, 2) == 0) ? MARK : 8'($urandom), 0);
               sent++;
            end
         end else begin
            send(OP_FLUSH, 8'($urandom), 0);
            sent++;
         end
      end

      drain();
      repeat (2000) @(posedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
